// ----- hw/rtl/scc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the segment checksum and CRC checker.
package scc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Item as held in the input register, header sum already reduced
    typedef struct packed {
        logic        kind;
        logic [19:0] hdr_sum;
        logic [15:0] urgent_field;
        logic [15:0] received_sum;
        logic [7:0]  payload_byte;
        logic        last;
    } t_item;

    // Finished segment report
    typedef struct packed {
        logic [15:0] checksum_value;
        logic        checksum_ok;
        logic [15:0] crc_value;
        logic        crc_ok;
    } t_result;

    // Advance the CRC by one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Fold the carries of a 32-bit sum into 16 bits, twice
    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
        s2 = {1'b0, s1[15:0]} + {16'h0000, s1[16]};
        return s2[15:0];
    endfunction

endpackage

// ----- hw/rtl/scc_accum.sv -----
// Running sum, running CRC and expected values for the segment in progress.
module scc_accum (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  scc_pkg::t_item         i_item,
    output scc_pkg::t_result       o_result
);
    import scc_pkg::*;

    logic [31:0] r_sum;
    logic [15:0] r_crc;
    logic [15:0] r_exp_sum;
    logic [15:0] r_exp_crc;

    logic [31:0] n_sum;
    logic [15:0] n_crc;
    logic [15:0] n_exp_sum;
    logic [15:0] n_exp_crc;
    logic [15:0] cks;

    // Restart on a header, accumulate on a payload byte
    always_comb begin
        if (i_item.kind == KIND_HEADER) begin
            n_sum     = {12'h000, i_item.hdr_sum};
            n_crc     = CRC_INIT;
            n_exp_sum = i_item.received_sum;
            n_exp_crc = i_item.urgent_field;
        end else begin
            n_sum     = r_sum + {24'h000000, i_item.payload_byte};
            n_crc     = crc_byte(r_crc, i_item.payload_byte);
            n_exp_sum = r_exp_sum;
            n_exp_crc = r_exp_crc;
        end
    end

    // Report on the updated state
    always_comb begin
        cks                     = ~fold_sum(n_sum);
        o_result.checksum_value = cks;
        o_result.checksum_ok    = (cks == n_exp_sum);
        o_result.crc_value      = n_crc;
        o_result.crc_ok         = (n_crc == n_exp_crc);
    end

    // Hold state until the item in the input register moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= 32'h0000_0000;
            r_crc     <= CRC_INIT;
            r_exp_sum <= 16'h0000;
            r_exp_crc <= 16'h0000;
        end else if (i_advance) begin
            r_sum     <= n_sum;
            r_crc     <= n_crc;
            r_exp_sum <= n_exp_sum;
            r_exp_crc <= n_exp_crc;
        end
    end

endmodule

// ----- hw/rtl/scc_out_reg.sv -----
// Result register with valid and ready toward the consumer.
module scc_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  scc_pkg::t_result       i_result,
    input  logic                   i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output scc_pkg::t_result       o_result
);
    import scc_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or draining this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture a new result, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hw/rtl/segment_checksum_crc_checker_unit.sv -----
// Top level of the segment checksum and CRC checker.
// Checks one segment as it streams in: a header transaction (i_kind = 0) starts it and
// payload-byte transactions (i_kind = 1) follow, one byte each. The header fields enter a
// 32-bit ones' complement sum as 16-bit halves (offset in bits 15..12 beside the flags),
// each payload byte is added as a single byte and also drives a CRC-16 (poly 0x8005,
// init 0xFFFF, MSB first). The transaction marked i_last yields one result: the folded
// and complemented sum, the CRC, and whether each matches the received checksum and the
// urgent pointer. The block takes one transaction per cycle while not stalled; each passes
// an input register and then the state update, and the result of a last transaction is
// loaded into the output register. The next transaction is accepted while a result waits
// in the output register; only a second last transaction stalls behind it.
module segment_checksum_crc_checker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [3:0]  i_header_words,
    input  logic [7:0]  i_flag_bits,
    input  logic [15:0] i_window_size,
    input  logic [15:0] i_urgent_field,
    input  logic [15:0] i_received_sum,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_checksum_value,
    output logic        o_checksum_ok,
    output logic [15:0] o_crc_value,
    output logic        o_crc_ok
);
    import scc_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_item   n_item;
    logic    out_free;
    logic    advance;
    logic    load;
    t_result acc_result;
    t_result out_result;

    // Reduce the header to one sum while capturing it
    always_comb begin
        n_item.kind         = i_kind;
        n_item.hdr_sum      = {4'h0, i_source_port} + {4'h0, i_dest_port}
                            + {4'h0, i_seq_number[31:16]} + {4'h0, i_seq_number[15:0]}
                            + {4'h0, i_ack_number[31:16]} + {4'h0, i_ack_number[15:0]}
                            + {4'h0, i_header_words, 4'h0, i_flag_bits}
                            + {4'h0, i_window_size} + {4'h0, i_urgent_field};
        n_item.urgent_field = i_urgent_field;
        n_item.received_sum = i_received_sum;
        n_item.payload_byte = i_payload_byte;
        n_item.last         = i_last;
    end

    // Advance unless a last transaction finds the output full
    assign advance = r_in_valid && (!r_item.last || out_free);
    assign load    = advance && r_item.last;
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    scc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (acc_result)
    );

    scc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_result (acc_result),
        .i_ready  (i_ready),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_checksum_value = out_result.checksum_value;
    assign o_checksum_ok    = out_result.checksum_ok;
    assign o_crc_value      = out_result.crc_value;
    assign o_crc_ok         = out_result.crc_ok;

endmodule

// ----- hw/rtl/scc_checker.sv -----
// Port-level assertions for the segment checker and their bind to the top level.
module scc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_checksum_value,
    input logic        o_checksum_ok,
    input logic [15:0] o_crc_value,
    input logic        o_crc_ok
);

    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Hold a stalled result and its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_checksum_value)
            && $stable(o_checksum_ok) && $stable(o_crc_value) && $stable(o_crc_ok)))
        else $error("stalled result changed");

    // Back-pressure only while a result waits unaccepted
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a waiting result");

    // A drained output with a free input never holds back the producer
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid) |-> o_ready)
        else $error("input not ready while output empty");

endmodule

bind segment_checksum_crc_checker_unit scc_checker u_scc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_checksum_value (o_checksum_value),
    .o_checksum_ok    (o_checksum_ok),
    .o_crc_value      (o_crc_value),
    .o_crc_ok         (o_crc_ok)
);

// ----- verif/segment_checksum_crc_checker_unit_tb.sv -----
// Testbench for the segment checksum and CRC checker: random segments against a scoreboard.
`timescale 1ns / 1ps

module segment_checksum_crc_checker_unit_tb;
    import scc_pkg::*;

    // One input transaction, every port field kept whatever the kind
    typedef struct packed {
        logic        kind;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  header_words;
        logic [7:0]  flag_bits;
        logic [15:0] window_size;
        logic [15:0] urgent_field;
        logic [15:0] received_sum;
        logic [7:0]  payload_byte;
        logic        last;
    } t_seg_item;

    // Segment predictor plus the queue of reports still due from the block
    class t_segment_check_model;
        logic [31:0] sum_acc;
        logic [15:0] crc_acc;
        logic [15:0] want_sum;
        logic [15:0] want_crc;
        t_result     reports_due[$];
        int unsigned mismatches;

        function new();
            sum_acc    = 32'h0000_0000;
            crc_acc    = CRC_INIT;
            want_sum   = 16'h0000;
            want_crc   = 16'h0000;
            mismatches = 0;
        endfunction

        // Advance the CRC by one byte, MSB first
        function logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] b);
            logic [15:0] c;
            logic        msb;
            c = crc ^ {b, 8'h00};
            repeat (8) begin
                msb = c[15];
                c   = c << 1;
                if (msb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        // Fold end-around carries twice
        function logic [15:0] fold_carries(input logic [31:0] s);
            logic [31:0] t;
            t = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
            t = {16'h0000, t[15:0]} + {16'h0000, t[31:16]};
            return t[15:0];
        endfunction

        // Update state for an accepted transaction; queue a report on last
        function void absorb_item(input t_seg_item it);
            t_result r;
            if (it.kind == KIND_HEADER) begin
                sum_acc = 32'(it.source_port) + 32'(it.dest_port)
                        + 32'(it.seq_number[31:16]) + 32'(it.seq_number[15:0])
                        + 32'(it.ack_number[31:16]) + 32'(it.ack_number[15:0])
                        + 32'({it.header_words, 4'b0000, it.flag_bits})
                        + 32'(it.window_size) + 32'(it.urgent_field);
                crc_acc  = CRC_INIT;
                want_sum = it.received_sum;
                want_crc = it.urgent_field;
            end else begin
                sum_acc = sum_acc + 32'(it.payload_byte);
                crc_acc = crc_advance(crc_acc, it.payload_byte);
            end
            if (it.last) begin
                r.checksum_value = ~fold_carries(sum_acc);
                r.checksum_ok    = (r.checksum_value == want_sum);
                r.crc_value      = crc_acc;
                r.crc_ok         = (crc_acc == want_crc);
                reports_due      = {reports_due, r};
            end
        endfunction

        task report_mismatch(input string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one accepted report against the oldest one due
        task check_report(input t_result got);
            t_result want;
            if (reports_due.size() == 0) begin
                report_mismatch($sformatf("unexpected report cks=%h crc=%h",
                                          got.checksum_value, got.crc_value));
            end else begin
                want = reports_due.pop_front();
                if (got.checksum_value !== want.checksum_value ||
                    got.checksum_ok !== want.checksum_ok ||
                    got.crc_value !== want.crc_value ||
                    got.crc_ok !== want.crc_ok) begin
                    report_mismatch($sformatf(
                        "cks %h/%h ok %b/%b crc %h/%h ok %b/%b (got/want)",
                        got.checksum_value, want.checksum_value,
                        got.checksum_ok, want.checksum_ok,
                        got.crc_value, want.crc_value, got.crc_ok, want.crc_ok));
                end
            end
        endtask

        task flag_leftovers();
            t_result want;
            while (reports_due.size() > 0) begin
                want = reports_due.pop_front();
                report_mismatch($sformatf("report never arrived cks=%h crc=%h",
                                          want.checksum_value, want.crc_value));
            end
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic        i_kind         = 1'b0;
    logic [15:0] i_source_port  = '0;
    logic [15:0] i_dest_port    = '0;
    logic [31:0] i_seq_number   = '0;
    logic [31:0] i_ack_number   = '0;
    logic [3:0]  i_header_words = '0;
    logic [7:0]  i_flag_bits    = '0;
    logic [15:0] i_window_size  = '0;
    logic [15:0] i_urgent_field = '0;
    logic [15:0] i_received_sum = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        i_last         = 1'b0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [15:0] o_checksum_value;
    logic        o_checksum_ok;
    logic [15:0] o_crc_value;
    logic        o_crc_ok;

    t_segment_check_model seg_model = new();
    t_result              seen_report;
    int                   items_sent   = 0;
    int                   hold_request = 0;
    bit                   no_gaps      = 1'b0;

    segment_checksum_crc_checker_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_source_port    (i_source_port),
        .i_dest_port      (i_dest_port),
        .i_seq_number     (i_seq_number),
        .i_ack_number     (i_ack_number),
        .i_header_words   (i_header_words),
        .i_flag_bits      (i_flag_bits),
        .i_window_size    (i_window_size),
        .i_urgent_field   (i_urgent_field),
        .i_received_sum   (i_received_sum),
        .i_payload_byte   (i_payload_byte),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_checksum_value (o_checksum_value),
        .o_checksum_ok    (o_checksum_ok),
        .o_crc_value      (o_crc_value),
        .o_crc_ok         (o_crc_ok)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Check every report transaction the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_report.checksum_value = o_checksum_value;
            seen_report.checksum_ok    = o_checksum_ok;
            seen_report.crc_value      = o_crc_value;
            seen_report.crc_ok         = o_crc_ok;
            seg_model.check_report(seen_report);
        end
    end

    // Drive the report side ready: long open runs, short stalls, rare long stalls
    initial begin : ready_driver
        int run_len;
        bit level;
        int pick;
        forever begin
            if (hold_request > 0) begin
                level        = 1'b0;
                run_len      = hold_request;
                hold_request = 0;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 4) begin
                    level   = 1'b1;
                    run_len = $urandom_range(1, 40);
                end else if (pick < 9) begin
                    level   = 1'b0;
                    run_len = $urandom_range(1, 3);
                end else begin
                    level   = 1'b0;
                    run_len = $urandom_range(10, 40);
                end
            end
            repeat (run_len) begin
                @(posedge i_clk);
                i_ready <= level;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Every field random; the kind decides which ones the block uses
    function automatic t_seg_item random_item(input logic kind, input logic last);
        t_seg_item it;
        it.kind         = kind;
        it.source_port  = 16'($urandom);
        it.dest_port    = 16'($urandom);
        it.seq_number   = $urandom;
        it.ack_number   = $urandom;
        it.header_words = 4'($urandom);
        it.flag_bits    = 8'($urandom);
        it.window_size  = 16'($urandom);
        it.urgent_field = 16'($urandom);
        it.received_sum = 16'($urandom);
        it.payload_byte = 8'($urandom);
        it.last         = last;
        return it;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input t_seg_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= it.kind;
        i_source_port  <= it.source_port;
        i_dest_port    <= it.dest_port;
        i_seq_number   <= it.seq_number;
        i_ack_number   <= it.ack_number;
        i_header_words <= it.header_words;
        i_flag_bits    <= it.flag_bits;
        i_window_size  <= it.window_size;
        i_urgent_field <= it.urgent_field;
        i_received_sum <= it.received_sum;
        i_payload_byte <= it.payload_byte;
        i_last         <= it.last;
        do @(posedge i_clk); while (!o_ready);
        seg_model.absorb_item(it);
        items_sent++;
    endtask

    // Build and send header plus payload; optionally make either check pass
    task automatic run_segment(input int n_bytes, input bit match_sum, input bit match_crc);
        t_seg_item            seg[$];
        t_segment_check_model probe;
        t_result              r;
        seg = {seg, random_item(KIND_HEADER, n_bytes == 0)};
        for (int k = 0; k < n_bytes; k++) begin
            seg = {seg, random_item(KIND_PAYLOAD, k == n_bytes - 1)};
        end
        // The CRC does not depend on the urgent field, so settle it first
        if (match_crc) begin
            probe = new();
            foreach (seg[k]) probe.absorb_item(seg[k]);
            r = probe.reports_due[$];
            seg[0].urgent_field = r.crc_value;
        end
        if (match_sum) begin
            probe = new();
            foreach (seg[k]) probe.absorb_item(seg[k]);
            r = probe.reports_due[$];
            seg[0].received_sum = r.checksum_value;
        end
        foreach (seg[k]) send_item(seg[k]);
    endtask

    // Main sequence
    initial begin
        t_seg_item  it;
        logic [7:0] extremes [3];
        int         pick;
        int         len;
        bit         hold_done;

        extremes  = '{8'hFF, 8'h00, 8'h80};
        hold_done = 1'b0;

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Stray payload before any header, closed by a last byte
        it = random_item(KIND_PAYLOAD, 1'b0);
        it.payload_byte = 8'hFF;
        send_item(it);
        it = random_item(KIND_PAYLOAD, 1'b1);
        it.payload_byte = 8'h00;
        send_item(it);

        // Header-only segments: zero sum checks against all ones, then both checks pass
        it = '0;
        it.kind         = KIND_HEADER;
        it.last         = 1'b1;
        it.received_sum = 16'hFFFF;
        send_item(it);
        it = '0;
        it.kind         = KIND_HEADER;
        it.last         = 1'b1;
        it.urgent_field = 16'hFFFF;
        send_item(it);

        // Every header field at its maximum, then extreme payload bytes
        it = '1;
        it.kind = KIND_HEADER;
        it.last = 1'b0;
        send_item(it);
        for (int k = 0; k < 3; k++) begin
            it = '1;
            it.kind         = KIND_PAYLOAD;
            it.payload_byte = extremes[k];
            it.last         = (k == 2);
            send_item(it);
        end

        // Payload after a finished segment keeps adding to its state
        it = random_item(KIND_PAYLOAD, 1'b1);
        it.payload_byte = 8'h5A;
        send_item(it);

        // Abandoned header replaced by a fresh one
        send_item(random_item(KIND_HEADER, 1'b0));
        send_item(random_item(KIND_HEADER, 1'b1));

        // Short segments with matching checksum and CRC, then with only one of them matching
        run_segment(3, 1'b1, 1'b1);
        run_segment(0, 1'b1, 1'b1);
        run_segment(1, 1'b1, 1'b0);
        run_segment(2, 1'b0, 1'b1);

        // Random part: mostly well-formed segments, some strays and broken headers
        while (items_sent < 1045) begin
            // Stall the report side for a long stretch while input keeps coming
            if (items_sent >= 400 && !hold_done) begin
                hold_done    = 1'b1;
                no_gaps      = 1'b1;
                hold_request = 300;
            end
            if (items_sent >= 600) begin
                no_gaps = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                  : $urandom_range(0, 12);
                run_segment(len, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
            end else if (pick < 92) begin
                send_item(random_item(KIND_PAYLOAD, 1'($urandom)));
            end else begin
                send_item(random_item(KIND_HEADER, 1'b0));
            end
        end

        // Drain outstanding reports, then let the pipeline settle
        i_valid <= 1'b0;
        for (int w = 0; w < 20000 && seg_model.reports_due.size() > 0; w++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        seg_model.flag_leftovers();

        if (seg_model.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/scc_pkg.sv
hw/rtl/scc_accum.sv
hw/rtl/scc_out_reg.sv
hw/rtl/segment_checksum_crc_checker_unit.sv
hw/rtl/scc_checker.sv
verif/segment_checksum_crc_checker_unit_tb.sv
